// ===== rtl/core/orwa_pkg.sv =====
package orwa_pkg;

  localparam int unsigned WindowDefault = 5;
  localparam int unsigned SampleW       = 12;
  localparam int unsigned AvgW          = 16;
  localparam int unsigned FracBits      = 4;
  localparam int unsigned ThrW          = 12;

  // divisor width covers windows up to 16 entries
  localparam int unsigned KW         = 5;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] RecipOne = RecipW'(64'd1 << RecipShift);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUM,
    ST_MUL,
    ST_FIX,
    ST_TEST,
    ST_EMIT
  } orwa_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic sum_clr;
    logic sum_step;
    logic mul;
    logic fix;
    logic test;
    logic emit;
  } orwa_cmd_t;

  typedef struct packed {
    logic replace;
    logic empty;
    logic sum_last;
  } orwa_stat_t;

  // floor(2^RecipShift / k); with the numerator below 2^RecipShift the
  // quotient is exact or one short
  function automatic logic [RecipW-1:0] recip(input logic [KW-1:0] k);
    logic [RecipW-1:0] r;
    case (k)
      5'd1:    r = RecipOne;
      5'd2:    r = RecipW'(RecipOne / 2);
      5'd3:    r = RecipW'(RecipOne / 3);
      5'd4:    r = RecipW'(RecipOne / 4);
      5'd5:    r = RecipW'(RecipOne / 5);
      5'd6:    r = RecipW'(RecipOne / 6);
      5'd7:    r = RecipW'(RecipOne / 7);
      5'd8:    r = RecipW'(RecipOne / 8);
      5'd9:    r = RecipW'(RecipOne / 9);
      5'd10:   r = RecipW'(RecipOne / 10);
      5'd11:   r = RecipW'(RecipOne / 11);
      5'd12:   r = RecipW'(RecipOne / 12);
      5'd13:   r = RecipW'(RecipOne / 13);
      5'd14:   r = RecipW'(RecipOne / 14);
      5'd15:   r = RecipW'(RecipOne / 15);
      5'd16:   r = RecipW'(RecipOne / 16);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/orwa_ctrl.sv =====
module orwa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  orwa_pkg::orwa_stat_t  stat_i,
  output orwa_pkg::orwa_cmd_t   cmd_o
);
  import orwa_pkg::*;

  orwa_state_e state_q, state_d;
  logic        second_q, second_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep    = 1'b1;
        cmd_o.sum_clr = 1'b1;
        second_d      = 1'b0;
        state_d       = stat_i.replace ? ST_SUM : ST_TEST;
      end
      ST_SUM: begin
        if (stat_i.empty) begin
          // no kept entries: mean holds
          state_d = second_q ? ST_EMIT : ST_TEST;
        end else begin
          cmd_o.sum_step = 1'b1;
          if (stat_i.sum_last) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = second_q ? ST_EMIT : ST_TEST;
      end
      ST_TEST: begin
        cmd_o.test    = 1'b1;
        cmd_o.sum_clr = 1'b1;
        second_d      = 1'b1;
        state_d       = ST_SUM;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // a result is only offered after the final mean pass
  a_emit_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> second_q)
    else $error("emit reached before outlier test");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("output valid raised outside emit");

endmodule

// ===== rtl/core/orwa_datapath.sv =====
module orwa_datapath #(
  parameter int unsigned WINDOW = orwa_pkg::WindowDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [orwa_pkg::SampleW-1:0]   sample_i,
  input  logic [orwa_pkg::ThrW-1:0]      threshold_i,
  input  orwa_pkg::orwa_cmd_t            cmd_i,
  output orwa_pkg::orwa_stat_t           stat_o,
  output logic [orwa_pkg::AvgW-1:0]      filtered_average_o,
  output logic                           was_outlier_o
);
  import orwa_pkg::*;

  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned IdxW  = $clog2(WINDOW);
  localparam int unsigned SumW  = SampleW + $clog2(WINDOW);
  localparam int unsigned NW    = SumW + FracBits;
  localparam int unsigned ProdW = NW + RecipW;

  logic [SampleW-1:0] kept_q [WINDOW];
  logic [SampleW-1:0] kept_d [WINDOW];
  logic [SampleW-1:0] outl_q [WINDOW];
  logic [SampleW-1:0] outl_d [WINDOW];
  logic [CntW-1:0]    kc_q, kc_d, oc_q, oc_d;
  logic [AvgW-1:0]    mean_q, mean_d;
  logic [SumW-1:0]    acc_q, acc_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic               outlier_q, outlier_d;
  logic [SampleW-1:0] sample_q, sample_d;
  logic [AvgW-1:0]    avg_out_q, avg_out_d;
  logic               flag_out_q, flag_out_d;

  logic [CntW:0]      occ;
  logic               age, replace;
  logic [NW-1:0]      numer, q0, qk, rem, quot;
  logic [AvgW-1:0]    scaled, diff, thr_scaled;
  logic               is_outlier;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        kept_q[i] <= '0;
        outl_q[i] <= '0;
      end
      kc_q      <= CntW'(1);
      oc_q      <= '0;
      mean_q    <= '0;
      outlier_q <= 1'b0;
    end else begin
      kept_q    <= kept_d;
      outl_q    <= outl_d;
      kc_q      <= kc_d;
      oc_q      <= oc_d;
      mean_q    <= mean_d;
      outlier_q <= outlier_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    idx_q      <= idx_d;
    prod_q     <= prod_d;
    sample_q   <= sample_d;
    avg_out_q  <= avg_out_d;
    flag_out_q <= flag_out_d;
  end

  assign occ     = {1'b0, kc_q} + {1'b0, oc_q};
  assign age     = (occ >= (CntW + 1)'(WINDOW)) && (kc_q != '0);
  assign replace = (oc_q == CntW'(WINDOW - 1));

  assign numer = {acc_q, {FracBits{1'b0}}};
  assign q0    = prod_q[RecipShift +: NW];
  assign qk    = NW'(q0 * NW'(kc_q));
  assign rem   = numer - qk;
  // reciprocal estimate is at most one short
  assign quot  = (rem >= NW'(kc_q)) ? q0 + NW'(1) : q0;

  assign scaled     = {sample_q, {FracBits{1'b0}}};
  assign diff       = (scaled >= mean_q) ? scaled - mean_q : mean_q - scaled;
  assign thr_scaled = {threshold_i, {FracBits{1'b0}}};
  assign is_outlier = diff > thr_scaled;

  always_comb begin
    kept_d     = kept_q;
    outl_d     = outl_q;
    kc_d       = kc_q;
    oc_d       = oc_q;
    mean_d     = mean_q;
    acc_d      = acc_q;
    idx_d      = idx_q;
    prod_d     = prod_q;
    outlier_d  = outlier_q;
    sample_d   = sample_q;
    avg_out_d  = avg_out_q;
    flag_out_d = flag_out_q;

    if (cmd_i.load) begin
      sample_d = sample_i;
    end

    if (cmd_i.prep) begin
      if (age) begin
        kc_d = kc_q - CntW'(1);
        for (int i = 0; i < WINDOW - 1; i++) begin
          kept_d[i] = kept_q[i + 1];
        end
      end
      // a full outlier run takes over the window
      if (replace) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          kept_d[i] = outl_q[i];
        end
        kc_d = CntW'(WINDOW - 1);
        oc_d = '0;
      end
    end

    if (cmd_i.sum_clr) begin
      acc_d = '0;
      idx_d = '0;
    end

    if (cmd_i.sum_step) begin
      acc_d = acc_q + SumW'(kept_q[idx_q]);
      idx_d = idx_q + IdxW'(1);
    end

    if (cmd_i.mul) begin
      prod_d = ProdW'(numer) * ProdW'(recip(KW'(kc_q)));
    end

    if (cmd_i.fix) begin
      mean_d = quot[AvgW-1:0];
    end

    if (cmd_i.test) begin
      outlier_d = is_outlier;
      if (is_outlier) begin
        if (oc_q < CntW'(WINDOW)) begin
          outl_d[oc_q[IdxW-1:0]] = sample_q;
          oc_d = oc_q + CntW'(1);
        end
      end else begin
        if (kc_q < CntW'(WINDOW)) begin
          kept_d[kc_q[IdxW-1:0]] = sample_q;
          kc_d = kc_q + CntW'(1);
        end
        oc_d = '0;
      end
    end

    if (cmd_i.emit) begin
      avg_out_d  = mean_q;
      flag_out_d = outlier_q;
    end
  end

  assign stat_o.replace  = replace;
  assign stat_o.empty    = (kc_q == '0);
  assign stat_o.sum_last = (CntW'(idx_q) + CntW'(1)) == kc_q;

  assign filtered_average_o = avg_out_q;
  assign was_outlier_o      = flag_out_q;

  // kept plus rejected entries never overflow the window
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (CntW + 1)'(WINDOW))
    else $error("window occupancy overflow");

  a_sum_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum_step |-> CntW'(idx_q) < kc_q)
    else $error("summing beyond kept entries");

endmodule

// ===== rtl/core/outlier_rejecting_window_average.sv =====
// Outlier-rejecting moving average of 12-bit ADC samples.
//
// Input channel: sample_i with in_valid_i / in_ready_o; one beat per sample.
// Output channel: filtered_average_o (mean of kept samples, codes x16,
// truncated) and was_outlier_o with out_valid_o / out_ready_i; one result
// beat per input beat, in order.
// Config: APB write to address 0 sets outlier_threshold (12 bits, codes).
//
// One sample at a time. The mean pass walks the kept entries one per cycle
// through a single adder, then a reciprocal multiply and one correction step;
// when a full outlier run replaces the window there are two mean passes. The
// next sample is taken in the same cycle as the result goes valid.
// A new sample is taken while a finished result still waits; if the receiver
// stalls, the next result is held until the output register frees up.
// Reset: window holds one zero sample, outlier run empty, mean zero,
// threshold 124.
module outlier_rejecting_window_average #(
  parameter int unsigned WINDOW = orwa_pkg::WindowDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [orwa_pkg::SampleW-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [orwa_pkg::AvgW-1:0]     filtered_average_o,
  output logic                          was_outlier_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import orwa_pkg::*;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(124);

  logic [ThrW-1:0] thr_q;
  logic            reg_sel;
  orwa_cmd_t       cmd;
  orwa_stat_t      stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(thr_q) : '0;

  orwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  orwa_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_i           (sample_i),
    .threshold_i        (thr_q),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .filtered_average_o (filtered_average_o),
    .was_outlier_o      (was_outlier_o)
  );

endmodule

// ===== bench/outlier_rejecting_window_average_tb.sv =====
`timescale 1ns / 100ps

module outlier_rejecting_window_average_tb;

  localparam int unsigned WINDOW = orwa_pkg::WindowDefault;
  localparam int unsigned SW = orwa_pkg::SampleW;
  localparam int unsigned AW = orwa_pkg::AvgW;
  localparam int unsigned TW = orwa_pkg::ThrW;

  localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
  localparam logic [TW-1:0] THRESHOLD_RESET = 12'd124;
  localparam int unsigned CODE_MAX = (1 << SW) - 1;

  // settle margin covers a result with two mean passes and the control states
  localparam int unsigned SETTLE = 2 * (2 * WINDOW + 8);
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_PHASES = 13;
  localparam int unsigned PHASE_ITEMS = 150;

  typedef struct {
    logic [AW-1:0] avg;
    logic          rejected;
  } mean_beat_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [SW-1:0] sample = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [AW-1:0] avg_out;
  logic          outlier_out;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // shadow of the filter state
  logic [SW-1:0] win_q [WINDOW] = '{default: '0};
  int unsigned   win_n = 1;
  logic [SW-1:0] run_q [WINDOW] = '{default: '0};
  int unsigned   run_n = 0;
  logic [AW-1:0] mean_q = '0;
  logic [TW-1:0] thr_q = THRESHOLD_RESET;

  mean_beat_t  pending_means [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned rx_wait = 0;
  bit          no_idle = 1'b0;

  outlier_rejecting_window_average #(
    .WINDOW(WINDOW)
  ) uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .sample_i           (sample),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .filtered_average_o (avg_out),
    .was_outlier_o      (outlier_out),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic void refresh_mean();
    int unsigned sum;
    sum = 0;
    if (win_n == 0 || win_n > WINDOW) return;
    for (int i = 0; i < win_n; i++) sum += win_q[i];
    mean_q = AW'((sum * 16) / win_n);
  endfunction

  function automatic mean_beat_t filter_step(input logic [SW-1:0] s);
    mean_beat_t  res;
    int unsigned scaled;
    int unsigned dev;
    logic        rej;
    // age out the oldest kept entry
    if (win_n + run_n >= WINDOW && win_n > 0) begin
      win_n--;
      for (int i = 0; i < win_n && i + 1 < WINDOW; i++) win_q[i] = win_q[i+1];
    end
    // a long enough outlier run takes over the window
    if (run_n == WINDOW - 1) begin
      for (int i = 0; i < run_n; i++) win_q[i] = run_q[i];
      win_n = run_n;
      run_n = 0;
      refresh_mean();
    end
    scaled = 32'(s) * 16;
    dev = (scaled >= 32'(mean_q)) ? scaled - 32'(mean_q) : 32'(mean_q) - scaled;
    rej = dev > 32'(thr_q) * 16;
    if (rej) begin
      if (run_n < WINDOW) begin
        run_q[run_n] = s;
        run_n++;
      end
    end else begin
      if (win_n < WINDOW) begin
        win_q[win_n] = s;
        win_n++;
      end
      run_n = 0;
    end
    refresh_mean();
    res.avg = mean_q;
    res.rejected = rej;
    return res;
  endfunction

  function automatic logic [SW-1:0] clip_code(input int v);
    if (v < 0) return '0;
    if (v > int'(CODE_MAX)) return SW'(CODE_MAX);
    return SW'(v);
  endfunction

  // result side: random stalls drawn per beat
  always @(posedge clk) begin
    mean_beat_t exp_beat;
    if (out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("result beat avg=%0d with nothing pending", avg_out));
      end else begin
        exp_beat = pending_means.pop_front();
        if (avg_out !== exp_beat.avg)
          report_mismatch($sformatf("filtered_average %0d, predicted %0d",
                                    avg_out, exp_beat.avg));
        if (outlier_out !== exp_beat.rejected)
          report_mismatch($sformatf("was_outlier %0b, predicted %0b",
                                    outlier_out, exp_beat.rejected));
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 14);
    end
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [SW-1:0] s);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_means.push_back(filter_step(s));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write the threshold, then read it straight back
  task automatic set_threshold(input logic [TW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESHOLD_ADDR;
    pwdata <= {(32 - TW)'($urandom_range(0, (1 << (32 - TW)) - 1)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    thr_q = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[TW-1:0] !== value)
      report_mismatch($sformatf("threshold read %0d, written %0d", prdata[TW-1:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // 124 sits exactly on the default threshold from a zero mean
    send_sample(12'd0);
    send_sample(12'd124);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd2048);
    wait_results_drained();
  endtask

  task automatic test_threshold_extremes();
    set_threshold(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd0);
    wait_results_drained();
    // zero threshold: a run of full-scale codes takes over, mean reaches top
    set_threshold(12'd0);
    repeat (6) send_sample(12'd4095);
    wait_results_drained();
  endtask

  task automatic test_outlier_runs();
    set_threshold(12'd20);
    send_sample(12'd100);
    send_sample(12'd100);
    // outlier runs, against the full-scale mean left before, that replace the window
    repeat (3) send_sample(12'd3000);
    send_sample(12'd100);
    repeat (5) send_sample(12'd3000);
    wait_results_drained();
  endtask

  task automatic test_random_phases();
    int unsigned burst_left;
    int          far_base;
    int          centre;
    int          off;
    int unsigned pick;
    logic [SW-1:0] s;
    burst_left = 0;
    far_base = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_results_drained();
      case (ph)
        0: set_threshold(12'd0);
        1: set_threshold(12'd4095);
        2: set_threshold(12'd1);
        default: begin
          case ($urandom_range(0, 3))
            0: set_threshold(TW'($urandom_range(0, 31)));
            1: set_threshold(TW'($urandom_range(32, 300)));
            2: set_threshold(TW'($urandom_range(301, 4095)));
            default: set_threshold(TW'($urandom()));
          endcase
        end
      endcase
      no_idle = (ph % 4 == 3);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 49) no_idle = ($urandom_range(0, 3) == 0);
        if (ph == 5 && n == PHASE_ITEMS / 2) wait_results_drained();
        centre = int'(mean_q >> 4);
        if (burst_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            off = $urandom_range(0, int'(thr_q) + 1);
            s = clip_code($urandom_range(0, 1) ? centre + off : centre - off);
          end else if (pick < 85) begin
            burst_left = $urandom_range(1, WINDOW);
            far_base = (centre < 2048) ? $urandom_range(3500, CODE_MAX)
                                       : $urandom_range(0, 600);
          end else begin
            s = SW'($urandom());
          end
        end
        if (burst_left > 0) begin
          s = clip_code(far_base + $urandom_range(0, 16) - 8);
          burst_left--;
        end
        send_sample(s);
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_extremes();
    test_outlier_runs();
    test_random_phases();
    wait_results_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
